[src/assert_macros.svh]
// Assertion macros used by the RTL top level of the cache tag lookup block.
// Holds only macro definitions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/salru_pkg.sv]
// Package of the set-associative cache tag lookup: defaults, register codes
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps

package salru_pkg;

    localparam int SETS_DEF      = 64;
    localparam int WAYS_DEF      = 8;
    localparam int ADDR_BITS_DEF = 32;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_WAYS  = 2'd1;
    localparam logic [1:0] REG_SBITS = 2'd2;

    localparam logic       MODE_RST  = 1'b0;
    localparam logic [3:0] WAYS_RST  = 4'd8;
    localparam logic [2:0] SBITS_RST = 3'd6;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

[src/salru_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/salru_ctrl.sv]
// Controller of the cache tag lookup: clearing pass, accept and commit steps.
// Depends on salru_pkg for the command and status structs.
`timescale 1ns / 1ps

module salru_ctrl import salru_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_ready          = 1'b0;
        o_cmd.clear_step = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.commit     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/salru_dpath.sv]
// Datapath of the cache tag lookup: tag and recency memories, way search,
// victim choice, recency update and the result register.
// Depends on salru_pkg and salru_ram.
`timescale 1ns / 1ps

module salru_dpath import salru_pkg::*; #(
    parameter int SETS      = SETS_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [31:0] i_address,
    input  logic        i_mode,
    input  logic [3:0]  i_ways,
    input  logic [2:0]  i_sbits,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_hit
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WC_W   = $clog2(WAYS + 1);
    localparam int MAX_SB = $clog2(SETS + 1) - 1;
    localparam int MW     = 1 + RW;
    localparam int TW     = ADDR_BITS;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [RW-1:0] RANK_MAX = RW'(WAYS - 1);

    logic [SET_W-1:0]   r_set;
    logic [TW-1:0]      r_tag;
    logic [SET_W-1:0]   r_clr_cnt;
    logic               r_out_valid;
    logic               r_hit;

    logic [2:0]         w_sb;
    logic [31:0]        w_addr;
    logic [SET_W-1:0]   w_set;
    logic [TW-1:0]      w_tag;
    logic [WC_W-1:0]    w_nways;

    logic [WAYS*TW-1:0] w_tag_rd;
    logic [WAYS*MW-1:0] w_meta_rd;
    logic [WAYS*TW-1:0] w_tag_wr;
    logic [WAYS*MW-1:0] w_meta_wr;
    logic               w_found;

    logic               w_meta_we;
    logic [SET_W-1:0]   w_meta_waddr;
    logic [WAYS*MW-1:0] w_meta_wdata;

    assign w_sb   = (32'(i_sbits) > MAX_SB) ? 3'(MAX_SB) : i_sbits;
    assign w_addr = i_address & ADDR_MASK;
    assign w_set  = w_addr[SET_W-1:0] & SET_W'((32'd1 << w_sb) - 32'd1);
    assign w_tag  = TW'(w_addr >> w_sb);

    always_comb begin
        if (i_ways == 4'd0) begin
            w_nways = WC_W'(1);
        end else if (32'(i_ways) > WAYS) begin
            w_nways = WC_W'(WAYS);
        end else begin
            w_nways = WC_W'(i_ways);
        end
    end

    always_comb begin
        logic [TW-1:0]   tags   [WAYS];
        logic [RW-1:0]   rank   [WAYS];
        logic [WAYS-1:0] val;
        logic [WAYS-1:0] inuse;
        logic [WAYS-1:0] hit_vec;
        logic [WAYS-1:0] empty_vec;
        logic [RW-1:0]   hit_idx;
        logic [RW-1:0]   empty_idx;
        logic [RW-1:0]   vict;
        logic [RW-1:0]   target;
        logic [RW-1:0]   lim;
        logic            any_empty;
        logic            age_all;
        logic            nv;
        logic [RW-1:0]   nr;
        for (int w = 0; w < WAYS; w++) begin
            tags[w]      = w_tag_rd[w*TW +: TW];
            rank[w]      = w_meta_rd[w*MW +: RW];
            val[w]       = w_meta_rd[w*MW + RW];
            inuse[w]     = (32'(w) < 32'(w_nways));
            hit_vec[w]   = inuse[w] && val[w] && (tags[w] == r_tag);
            empty_vec[w] = inuse[w] && !val[w];
        end
        w_found   = |hit_vec;
        any_empty = |empty_vec;
        hit_idx   = '0;
        empty_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = RW'(w);
            end
            if (empty_vec[w]) begin
                empty_idx = RW'(w);
            end
        end
        vict = '0;
        for (int w = 1; w < WAYS; w++) begin
            if (inuse[w] && (i_mode ? (rank[w] < rank[vict]) : (rank[w] > rank[vict]))) begin
                vict = RW'(w);
            end
        end
        if (w_found) begin
            target = hit_idx;
        end else if (any_empty) begin
            target = empty_idx;
        end else begin
            target = vict;
        end
        lim     = rank[target];
        age_all = !w_found && any_empty;
        for (int w = 0; w < WAYS; w++) begin
            nv = val[w];
            nr = rank[w];
            if (inuse[w] && val[w] && (age_all || (rank[w] < lim)) && (rank[w] < RANK_MAX)) begin
                nr = rank[w] + RW'(1);
            end
            if (RW'(w) == target) begin
                nv = 1'b1;
                nr = '0;
                w_tag_wr[w*TW +: TW] = r_tag;
            end else begin
                w_tag_wr[w*TW +: TW] = tags[w];
            end
            w_meta_wr[w*MW +: MW] = {nv, nr};
        end
    end

    assign w_meta_we    = i_cmd.clear_step || i_cmd.commit;
    assign w_meta_waddr = i_cmd.clear_step ? r_clr_cnt : r_set;
    assign w_meta_wdata = i_cmd.clear_step ? '0 : w_meta_wr;

    salru_ram #(
        .WIDTH (WAYS * TW),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_set),
        .i_wdata (w_tag_wr),
        .i_re    (i_cmd.accept),
        .i_raddr (w_set),
        .o_rdata (w_tag_rd)
    );

    salru_ram #(
        .WIDTH (WAYS * MW),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (w_set),
        .o_rdata (w_meta_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= w_set;
            r_tag <= w_tag;
        end
        if (i_cmd.commit) begin
            r_hit <= w_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_cnt <= r_clr_cnt + SET_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last = (r_clr_cnt == SET_W'(SETS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;

endmodule

[src/set_assoc_cache_lru_mru_unit.sv]
// Set-associative cache tag lookup with LRU or MRU replacement; top level.
// A beat reads its set's row through a registered read; its hit result is
// registered at commit, which waits while the last result is not taken, and
// no new beat is taken until then. After reset a clearing pass zeroes the
// valid and recency memory while no beat is taken; control registers reset.
// Depends on salru_pkg, salru_ctrl, salru_dpath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_assoc_cache_lru_mru_unit import salru_pkg::*; #(
    parameter int SETS      = SETS_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_address,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       r_mode;
    logic [3:0] r_ways;
    logic [2:0] r_sbits;
    logic       w_wr;
    t_cmd       w_cmd;
    t_stat      w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_ways  <= WAYS_RST;
            r_sbits <= SBITS_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MODE:  r_mode  <= pwdata[0];
                REG_WAYS:  r_ways  <= pwdata[3:0];
                REG_SBITS: r_sbits <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:  prdata = {31'd0, r_mode};
            REG_WAYS:  prdata = {28'd0, r_ways};
            REG_SBITS: prdata = {29'd0, r_sbits};
            default:   prdata = 32'd0;
        endcase
    end

    salru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    salru_dpath #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_address   (i_address),
        .i_mode      (r_mode),
        .i_ways      (r_ways),
        .i_sbits     (r_sbits),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_hit       (o_hit)
    );

    `ASSERT_CLK_RST(a_commit_valid, i_clk, i_rst_n, w_cmd.commit |=> o_valid, "commit did not present a result")
    `ASSERT_CLK_RST(a_one_in_flight, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "second beat taken while one is in flight")
    `ASSERT_CLK_RST(a_clear_blocks, i_clk, i_rst_n, w_cmd.clear_step |-> !o_ready, "beat offered during clearing pass")
    `ASSERT_CLK(a_reset_clears, i_clk, !i_rst_n |=> !o_ready && !o_valid, "block ready right after reset")

endmodule

[tb/tb_set_assoc_cache_lru_mru_unit.sv]
// Self-checking testbench for set_assoc_cache_lru_mru_unit: drives address beats and
// register writes, and checks each hit beat against a cache tag model kept here.
// Depends on salru_pkg and the set_assoc_cache_lru_mru_unit RTL.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_mru_unit;
    import salru_pkg::*;

    localparam int SETS      = SETS_DEF;
    localparam int WAYS      = WAYS_DEF;
    localparam int MAX_SBITS = $clog2(SETS + 1) - 1;
    localparam int TAG_POOL  = 12;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 160;
    localparam int HIT_BUF   = 64;

    class cache_hit_tracker;
        logic [31:0] tag_mem [SETS][WAYS];
        bit          valid_mem [SETS][WAYS];
        int unsigned rank_mem [SETS][WAYS];
        bit          evict_mru;
        int unsigned ways_cfg;
        int unsigned sbits_cfg;
        bit          exp_hits [HIT_BUF];
        int unsigned exp_head;
        int unsigned exp_tail;
        int unsigned errors;

        function new();
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    tag_mem[s][w] = '0;
                    valid_mem[s][w] = 1'b0;
                    rank_mem[s][w] = 0;
                end
            end
            evict_mru = MODE_RST;
            ways_cfg = WAYS_RST;
            sbits_cfg = SBITS_RST;
            exp_head = 0;
            exp_tail = 0;
            errors = 0;
        endfunction

        function int unsigned num_pending();
            return exp_tail - exp_head;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MODE: begin
                    evict_mru = value[0];
                end
                REG_WAYS: begin
                    ways_cfg = value[3:0];
                end
                REG_SBITS: begin
                    sbits_cfg = value[2:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_access(logic [31:0] addr);
            int unsigned sb;
            int unsigned nways;
            int unsigned set_idx;
            int unsigned slot;
            int unsigned lim;
            logic [31:0] tag;
            bit found;
            bit has_empty;
            sb = (sbits_cfg > MAX_SBITS) ? MAX_SBITS : sbits_cfg;
            nways = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);
            set_idx = addr & ((32'd1 << sb) - 32'd1);
            tag = addr >> sb;
            found = 1'b0;
            slot = 0;
            for (int w = 0; w < nways; w++) begin
                if (!found && valid_mem[set_idx][w] && tag_mem[set_idx][w] == tag) begin
                    found = 1'b1;
                    slot = w;
                end
            end
            if (found) begin
                lim = rank_mem[set_idx][slot];
            end else begin
                has_empty = 1'b0;
                for (int w = 0; w < nways; w++) begin
                    if (!has_empty && !valid_mem[set_idx][w]) begin
                        has_empty = 1'b1;
                        slot = w;
                    end
                end
                if (has_empty) begin
                    lim = 32'hFFFF_FFFF;
                end else begin
                    slot = 0;
                    for (int w = 1; w < nways; w++) begin
                        if (evict_mru ? (rank_mem[set_idx][w] < rank_mem[set_idx][slot])
                                      : (rank_mem[set_idx][w] > rank_mem[set_idx][slot]))
                            slot = w;
                    end
                    lim = rank_mem[set_idx][slot];
                end
                valid_mem[set_idx][slot] = 1'b0;
            end
            // Ages saturate at the oldest rank the hardware can hold.
            for (int w = 0; w < nways; w++) begin
                if (valid_mem[set_idx][w] && rank_mem[set_idx][w] < lim
                        && rank_mem[set_idx][w] < WAYS - 1)
                    rank_mem[set_idx][w]++;
            end
            tag_mem[set_idx][slot] = tag;
            valid_mem[set_idx][slot] = 1'b1;
            rank_mem[set_idx][slot] = 0;
            exp_hits[exp_tail % HIT_BUF] = found;
            exp_tail++;
        endfunction

        function void check_hit(logic hit);
            bit want;
            if (exp_tail == exp_head) begin
                errors++;
                if (errors <= 10)
                    $display("hit beat with nothing pending: got %b", hit);
            end else begin
                want = exp_hits[exp_head % HIT_BUF];
                exp_head++;
                if (hit !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("hit: expected %b got %b", want, hit);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [31:0]        i_address = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_hit;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    cache_hit_tracker tracker = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_req = 1'b0;
    logic        rx_hold = 1'b0;
    logic [31:0] tag_pool [TAG_POOL];

    int unsigned cfg_mode  [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
    int unsigned cfg_ways  [PHASES] = '{8, 8, 1, 1, 0, 15, 4, 3, 8, 2, 9, 8};
    int unsigned cfg_sbits [PHASES] = '{6, 6, 0, 6, 7, 2, 3, 1, 0, 6, 4, 5};

    set_assoc_cache_lru_mru_unit u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_address (i_address),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_hit     (o_hit),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always begin
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (64) @(posedge i_clk);
        rx_hold <= 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                tracker.check_hit(o_hit);
            if (i_valid && o_ready)
                tracker.note_access(i_address);
        end
    end

    task automatic send_access(input logic [31:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_address <= addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.num_pending() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_address();
        int unsigned sb;
        logic [31:0] tag_part;
        logic [31:0] set_part;
        sb = (tracker.sbits_cfg > MAX_SBITS) ? MAX_SBITS : tracker.sbits_cfg;
        if ($urandom_range(0, 99) < 8)
            return $urandom();
        tag_part = tag_pool[$urandom_range(0, TAG_POOL - 1)];
        set_part = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SETS - 1)
                                               : $urandom_range(0, 3);
        return (tag_part << sb) | (set_part & ((32'd1 << sb) - 32'd1));
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The valid and recency memory is cleared after reset before beats are taken.
        do @(posedge i_clk); while (!o_ready);

        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        for (int t = 1; t <= 9; t++)
            send_access((t << 6) | 5);
        send_access((32'd1 << 6) | 5);
        send_access((32'd3 << 6) | 5);
        wait_drained();
        write_reg(REG_MODE, 32'd1);
        send_access((32'd10 << 6) | 5);
        send_access((32'd3 << 6) | 5);
        send_access(32'h8000_0000);
        send_access(32'h7FFF_FFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(REG_MODE, cfg_mode[ph]);
            write_reg(REG_WAYS, cfg_ways[ph]);
            write_reg(REG_SBITS, cfg_sbits[ph]);
            for (int k = 0; k < TAG_POOL; k++)
                tag_pool[k] = (k < 4) ? k : $urandom();
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 52;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 52;
                end
                default: begin
                    send_idle_pct = 10;
                    stall_pct = 10;
                end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 4 && n == 40)
                    hold_req = 1'b1;
                if (ph == 6 && n == 80)
                    wait_drained();
                send_access(pick_address());
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.num_pending() == 0) begin
            $display("set_assoc_cache_lru_mru_unit: match");
        end else begin
            $display("set_assoc_cache_lru_mru_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("set_assoc_cache_lru_mru_unit: mismatch");
        $finish;
    end

endmodule
